// File: hdl/philox_counter_rng_draw_top_defines.svh
// Assertion macros shared by the Philox draw pipeline.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef PHILOX_COUNTER_RNG_DRAW_TOP_DEFINES_SVH
`define PHILOX_COUNTER_RNG_DRAW_TOP_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while in reset.
`define PCTR_ASSERT_NOW(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("%m: check failed");
// Next-cycle implication, disabled while in reset.
`define PCTR_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("%m: check failed");
`else
`define PCTR_ASSERT_NOW(label, clk, rst_n, lhs, rhs)
`define PCTR_ASSERT_NEXT(label, clk, rst_n, lhs, rhs)
`endif
`endif

// File: hdl/pctr_pkg.sv
// Constants and stage types for the Philox 4x32 draw pipeline.
// No dependencies; used by pctr_round and the top level.
`timescale 1ns / 1ps
package pctr_pkg;

    localparam int ROUNDS_DEFAULT = 10;

    localparam logic [31:0] MUL_A  = 32'hd2511f53;
    localparam logic [31:0] MUL_B  = 32'hcd9e8d57;
    localparam logic [31:0] BUMP_A = 32'h9e3779b9;
    localparam logic [31:0] BUMP_B = 32'hbb67ae85;

    // One pipeline slot: four block words, the round key and the half select.
    typedef struct packed {
        logic        valid;
        logic        half;
        logic [31:0] w0;
        logic [31:0] w1;
        logic [31:0] w2;
        logic [31:0] w3;
        logic [31:0] k0;
        logic [31:0] k1;
    } lane_t;

endpackage

// File: hdl/pctr_round.sv
// One registered Philox 4x32 round with key bump for the following round.
// Depends on pctr_pkg and philox_counter_rng_draw_top_defines.svh.
`timescale 1ns / 1ps
`include "philox_counter_rng_draw_top_defines.svh"
module pctr_round
(
    input  logic          clk,
    input  logic          rst_n,
    input  pctr_pkg::lane_t src,
    output pctr_pkg::lane_t dst
);

    logic [63:0]     prod_a;
    logic [63:0]     prod_b;
    logic            valid_reg;
    pctr_pkg::lane_t data_next;
    pctr_pkg::lane_t data_reg;

    assign prod_a = {32'd0, pctr_pkg::MUL_A} * {32'd0, src.w0};
    assign prod_b = {32'd0, pctr_pkg::MUL_B} * {32'd0, src.w2};

    always_comb
    begin
        data_next       = src;
        data_next.w0    = prod_b[63:32] ^ src.w1 ^ src.k0;
        data_next.w1    = prod_b[31:0];
        data_next.w2    = prod_a[63:32] ^ src.w3 ^ src.k1;
        data_next.w3    = prod_a[31:0];
        // advance the key; the bump after the last round is never used
        data_next.k0    = src.k0 + pctr_pkg::BUMP_A;
        data_next.k1    = src.k1 + pctr_pkg::BUMP_B;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= src.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_comb
    begin
        dst       = data_reg;
        dst.valid = valid_reg;
    end

    `PCTR_ASSERT_NEXT(a_valid_moves, clk, rst_n, src.valid, dst.valid)
    `PCTR_ASSERT_NEXT(a_no_phantom, clk, rst_n, !src.valid, !dst.valid)
    `PCTR_ASSERT_NEXT(a_key_bump, clk, rst_n, src.valid,
        (dst.k0 == $past(src.k0) + pctr_pkg::BUMP_A) && (dst.k1 == $past(src.k1) + pctr_pkg::BUMP_B))

endmodule

// File: hdl/philox_counter_rng_draw_top.sv
// Top level of the Philox 4x32 draw generator: key register, round chain, output select.
// Depends on pctr_pkg and pctr_round.
`timescale 1ns / 1ps
//
// Usage:
//   Raise start with draw_index for one cycle per transaction; busy is always
//   low, so a new draw ordinal is taken at every clock edge where start is high.
//   Each transaction yields one 64-bit random_value, shown for exactly one cycle
//   with done high. The draw passes through the round registers and then the
//   output register. Throughput is one draw per cycle: each round owns its
//   pipeline stage with two 32x32 multipliers, and a final register selects
//   the half. Results leave in the order draws were taken.
//   The key is written through key_write / stream_key; it is sampled when a
//   draw enters and travels with it, so write it only while no draw is in flight.
//   Reset clears the key to zero and drops every draw in flight.
//   The receiver cannot stall: done is a strobe and must be taken when it fires.
//
module philox_counter_rng_draw_top
#(
    parameter int ROUNDS = pctr_pkg::ROUNDS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] draw_index,
    output logic        done,
    output logic [63:0] random_value,
    input  logic        key_write,
    input  logic [63:0] stream_key
);

    logic [63:0]     key_reg;
    logic            done_reg;
    logic [63:0]     value_reg;
    logic [63:0]     value_next;
    pctr_pkg::lane_t lanes [ROUNDS + 1];

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= 64'd0;
        end
        else if (key_write)
        begin
            key_reg <= stream_key;
        end
    end

    // block counter is the ordinal shifted right by one
    always_comb
    begin
        lanes[0].valid = start;
        lanes[0].half  = draw_index[0];
        lanes[0].w0    = {1'b0, draw_index[63:33]};
        lanes[0].w1    = draw_index[32:1];
        lanes[0].w2    = 32'd0;
        lanes[0].w3    = 32'd0;
        lanes[0].k0    = key_reg[31:0];
        lanes[0].k1    = key_reg[63:32];
    end

    for (genvar r = 0; r < ROUNDS; r++)
    begin : g_round
        pctr_round u_round
        (
            .clk   (clk),
            .rst_n (rst_n),
            .src   (lanes[r]),
            .dst   (lanes[r + 1])
        );
    end

    assign value_next = lanes[ROUNDS].half ? {lanes[ROUNDS].w2, lanes[ROUNDS].w3}
                                           : {lanes[ROUNDS].w0, lanes[ROUNDS].w1};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= lanes[ROUNDS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign done         = done_reg;
    assign random_value = value_reg;

endmodule

// File: dv/tb_top.sv
// Self-checking testbench for the Philox 4x32 draw generator (philox_counter_rng_draw_top).
// Depends only on the RTL; it carries its own bit-exact predictor of each draw.
`timescale 1ns / 1ps

module tb_top;

    localparam int          N_ROUNDS  = 10;
    localparam logic [31:0] MULT_LO   = 32'hd2511f53;
    localparam logic [31:0] MULT_HI   = 32'hcd9e8d57;
    localparam logic [31:0] WEYL_LO   = 32'h9e3779b9;
    localparam logic [31:0] WEYL_HI   = 32'hbb67ae85;
    localparam int          N_PHASES  = 8;
    localparam int          PHASE_LEN = 125;

    typedef enum logic [1:0] {
        OP_DRAW,
        OP_KEY,
        OP_DRAIN
    } step_kind_e;

    typedef struct {
        step_kind_e  kind;
        logic [63:0] value;
    } stim_step_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [63:0] draw_index = '0;
    logic        key_write = 1'b0;
    logic [63:0] stream_key = '0;
    logic        busy;
    logic        done;
    logic [63:0] random_value;

    stim_step_t  pend_q[$];
    logic [63:0] draw_exp_q[$];
    logic [63:0] key_now = '0;
    int          n_draw_items = 0;
    int          n_accepted = 0;
    int          n_keys = 0;
    int          n_checked = 0;
    int          n_fail = 0;
    int          gap_left = 0;
    int          burst_left = 1;

    philox_counter_rng_draw_top #(
        .ROUNDS (N_ROUNDS)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .draw_index   (draw_index),
        .done         (done),
        .random_value (random_value),
        .key_write    (key_write),
        .stream_key   (stream_key)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Ten Philox 4x32 rounds over the block counter, then pick the half by bit 0.
    function automatic logic [63:0] philox_draw(input logic [63:0] ordinal,
                                                input logic [63:0] key);
        logic [63:0] ctr;
        logic [63:0] prod_a;
        logic [63:0] prod_b;
        logic [31:0] x0;
        logic [31:0] x1;
        logic [31:0] x2;
        logic [31:0] x3;
        logic [31:0] ka;
        logic [31:0] kb;
        ctr = ordinal >> 1;
        x0  = ctr[63:32];
        x1  = ctr[31:0];
        x2  = '0;
        x3  = '0;
        ka  = key[31:0];
        kb  = key[63:32];
        for (int r = 0; r < N_ROUNDS; r++)
        begin
            prod_a = 64'(MULT_LO) * 64'(x0);
            prod_b = 64'(MULT_HI) * 64'(x2);
            x0 = prod_b[63:32] ^ x1 ^ ka;
            x1 = prod_b[31:0];
            x2 = prod_a[63:32] ^ x3 ^ kb;
            x3 = prod_a[31:0];
            if (r != N_ROUNDS - 1)
            begin
                ka = ka + WEYL_LO;
                kb = kb + WEYL_HI;
            end
        end
        return ordinal[0] ? {x2, x3} : {x0, x1};
    endfunction

    task automatic add_step(input step_kind_e kind, input logic [63:0] value);
        stim_step_t s;
        s.kind  = kind;
        s.value = value;
        pend_q.insert(pend_q.size(), s);
        if (kind == OP_DRAW)
            n_draw_items++;
    endtask

    // Driver: record accepted transactions, then present the next step.
    always @(posedge clk)
    begin : drive_proc
        logic       nxt_start;
        logic       nxt_kw;
        stim_step_t step;
        if (!rst_n)
        begin
            start     <= 1'b0;
            key_write <= 1'b0;
        end
        else
        begin
            if (key_write)
                key_now = stream_key;
            if (start && !busy)
            begin
                draw_exp_q.insert(draw_exp_q.size(), philox_draw(draw_index, key_now));
                n_accepted++;
            end
            // hold an unaccepted draw as it is
            nxt_start = start && busy;
            nxt_kw    = 1'b0;
            if (!nxt_start && pend_q.size() > 0)
            begin
                step = pend_q[0];
                case (step.kind)
                    OP_DRAW:
                        if (gap_left > 0)
                            gap_left--;
                        else
                        begin
                            draw_index <= step.value;
                            nxt_start = 1'b1;
                            void'(pend_q.pop_front());
                            if (burst_left <= 1)
                            begin
                                burst_left = $urandom_range(1, 40);
                                gap_left   = ($urandom_range(0, 3) == 0) ? 0
                                                                         : $urandom_range(1, 6);
                            end
                            else
                                burst_left--;
                        end
                    OP_KEY:
                        if (draw_exp_q.size() == 0)
                        begin
                            stream_key <= step.value;
                            nxt_kw = 1'b1;
                            n_keys++;
                            void'(pend_q.pop_front());
                        end
                    OP_DRAIN:
                        if (draw_exp_q.size() == 0)
                            void'(pend_q.pop_front());
                    default:
                        void'(pend_q.pop_front());
                endcase
            end
            start     <= nxt_start;
            key_write <= nxt_kw;
        end
    end

    // Monitor: sample mid-cycle, the strobe is stable between edges.
    always @(negedge clk)
    begin : watch_proc
        logic [63:0] want;
        if (rst_n && done)
        begin
            if (draw_exp_q.size() == 0)
            begin
                $error("random_value: no draw outstanding, got %h", random_value);
                n_fail++;
            end
            else
            begin
                want = draw_exp_q.pop_front();
                n_checked++;
                if (random_value !== want)
                begin
                    $error("random_value: expected %h, actual %h", want, random_value);
                    n_fail++;
                end
            end
        end
    end

    initial
    begin : stim_proc
        logic [63:0] ord;
        logic [63:0] run_next;
        logic [63:0] phase_key[N_PHASES];
        int          drain_at;

        // directed draws under the reset key
        add_step(OP_DRAW, 64'h0);
        add_step(OP_DRAW, 64'h1);
        add_step(OP_DRAW, 64'h2);
        add_step(OP_DRAW, 64'h3);
        add_step(OP_DRAW, 64'hFFFF_FFFF_FFFF_FFFF);
        add_step(OP_DRAW, 64'hFFFF_FFFF_FFFF_FFFE);
        add_step(OP_DRAW, 64'h8000_0000_0000_0000);
        add_step(OP_DRAW, 64'h8000_0000_0000_0001);
        add_step(OP_DRAW, 64'h0000_0001_FFFF_FFFE);
        add_step(OP_DRAW, 64'h0000_0002_0000_0000);
        add_step(OP_DRAW, 64'hAAAA_AAAA_AAAA_AAAA);
        add_step(OP_DRAW, 64'h5555_5555_5555_5555);
        add_step(OP_DRAW, 64'h7FFF_FFFF_FFFF_FFFF);
        add_step(OP_DRAW, 64'hFFFF_FFFF_0000_0001);
        add_step(OP_DRAIN, 64'h0);

        phase_key[0] = 64'hFFFF_FFFF_FFFF_FFFF;
        phase_key[1] = 64'h0;
        phase_key[2] = 64'h0000_0000_FFFF_FFFF;
        phase_key[3] = 64'hFFFF_FFFF_0000_0000;
        for (int p = 4; p < N_PHASES; p++)
            phase_key[p] = {$urandom, $urandom};

        run_next = {$urandom, $urandom};
        for (int p = 0; p < N_PHASES; p++)
        begin
            add_step(OP_KEY, phase_key[p]);
            if (p == 0)
            begin
                add_step(OP_DRAW, 64'h0);
                add_step(OP_DRAW, 64'h1);
                add_step(OP_DRAW, 64'hFFFF_FFFF_FFFF_FFFE);
                add_step(OP_DRAW, 64'hFFFF_FFFF_FFFF_FFFF);
            end
            drain_at = $urandom_range(10, PHASE_LEN - 10);
            for (int i = 0; i < PHASE_LEN; i++)
            begin
                if (i == drain_at)
                    add_step(OP_DRAIN, 64'h0);
                case ($urandom_range(0, 7))
                    0, 1, 2:
                    begin
                        ord      = {$urandom, $urandom};
                        run_next = ord + 64'd1;
                    end
                    3:       ord = 64'($urandom_range(0, 255));
                    4:       ord = ~64'($urandom_range(0, 255));
                    default:
                    begin
                        // consecutive ordinals, as a workload walks its stream
                        ord      = run_next;
                        run_next = run_next + 64'd1;
                    end
                endcase
                add_step(OP_DRAW, ord);
            end
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        while (n_accepted < n_draw_items || draw_exp_q.size() != 0)
            @(posedge clk);
        repeat (N_ROUNDS + 4) @(posedge clk);

        $display("Covered %0d draws over %0d key settings (both halves, counter extremes);",
                 n_accepted, n_keys);
        $display("%0d results compared, %0d mismatches.", n_checked, n_fail);
        if (n_fail == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #1_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: philox_counter_rng_draw_top.f
+incdir+hdl
hdl/pctr_pkg.sv
hdl/pctr_round.sv
hdl/philox_counter_rng_draw_top.sv
dv/tb_top.sv
